// ===== rtl/core/pci_config_scan_matcher_defines.svh =====
// assertion macros for the pci config scan matcher
// used by pcsm_back to check its own control logic
`ifndef PCI_CONFIG_SCAN_MATCHER_DEFINES_SVH
`define PCI_CONFIG_SCAN_MATCHER_DEFINES_SVH

`ifndef SYNTH
// check a property on every rising edge outside reset
`define PCSM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcsm assertion failed");
// check a property on every rising edge, reset included
`define PCSM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pcsm assertion failed");
`else
`define PCSM_ASSERT(label, clk, rst, prop)
`define PCSM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/pcsm_pkg.sv =====
// shared types and constants of the pci config scan matcher
// no dependencies
`timescale 1ns / 1ps

package pcsm_pkg;

  localparam int BUS_COUNT_DEF  = 256;
  localparam int SLOT_COUNT_DEF = 32;
  localparam int FUNC_COUNT_DEF = 8;
  localparam int BAR_COUNT_DEF  = 6;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VENDOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 3'd4;

  // match modes
  localparam logic [1:0] MODE_ANY   = 2'd0;
  localparam logic [1:0] MODE_ID    = 2'd1;
  localparam logic [1:0] MODE_CLASS = 2'd2;

  // operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_READ      = 2'd0;
  localparam logic [1:0] KIND_BAR       = 2'd1;
  localparam logic [1:0] KIND_FOUND     = 2'd2;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd3;

  // config space offsets and fields
  localparam logic [7:0]  OFF_ID      = 8'h00;
  localparam logic [7:0]  OFF_CLASS   = 8'h08;
  localparam logic [7:0]  OFF_HDR     = 8'h0C;
  localparam logic [7:0]  OFF_BAR     = 8'h10;
  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam int          HDR_MULTI_BIT = 23;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] vendor;
    logic [15:0] device;
    logic [23:0] class_val;
    logic [15:0] index;
  } cfg_t;

  // classified input item
  typedef struct packed {
    logic        start;
    logic        absent;
    logic        multi;
    logic        id_match;
    logic        class_match;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cfg_address;
    logic [2:0]  bar_index;
    logic [31:0] bar_value;
    logic [7:0]  bus_number;
    logic [4:0]  slot_number;
    logic [2:0]  function_number;
    logic [31:0] id_word;
    logic [23:0] class_triple;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/pcsm_if.sv =====
// handshake channels of the pci config scan matcher
// no dependencies
`timescale 1ns / 1ps

interface pcsm_feed_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] read_data;

  modport source (output valid, operation, read_data, input ready);
  modport sink (input valid, operation, read_data, output ready);
endinterface

interface pcsm_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] cfg_address;
  logic [2:0]  bar_index;
  logic [31:0] bar_value;
  logic [7:0]  bus_number;
  logic [4:0]  slot_number;
  logic [2:0]  function_number;
  logic [31:0] id_word;
  logic [23:0] class_triple;
  logic        last;

  modport source (output valid, kind, cfg_address, bar_index, bar_value, bus_number,
                  slot_number, function_number, id_word, class_triple, last,
                  input ready);
  modport sink (input valid, kind, cfg_address, bar_index, bar_value, bus_number,
                slot_number, function_number, id_word, class_triple, last,
                output ready);
endinterface

// ===== rtl/core/pcsm_front.sv =====
// front end: accepts items and classifies the returned dword
// depends on pcsm_pkg and pcsm_feed_if
`timescale 1ns / 1ps

module pcsm_front (
  pcsm_feed_if.sink         feed,
  input  pcsm_pkg::cfg_t    cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output pcsm_pkg::cmd_t    push_cmd
);
  import pcsm_pkg::*;

  logic [31:0] d;

  assign d          = feed.read_data;
  assign feed.ready = push_ready;
  assign push_valid = feed.valid;

  always_comb begin
    push_cmd             = '0;
    push_cmd.start       = (feed.operation == OP_START);
    push_cmd.absent      = (d[15:0] == VENDOR_NONE);
    push_cmd.multi       = d[HDR_MULTI_BIT];
    push_cmd.id_match    = (d[15:0] == cfg.vendor) && (d[31:16] == cfg.device);
    push_cmd.class_match = (d[31:8] == cfg.class_val);
    push_cmd.data        = d;
  end

endmodule

// ===== rtl/core/pcsm_queue.sv =====
// two-entry queue of classified items between front and back
// depends on pcsm_pkg
`timescale 1ns / 1ps

module pcsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcsm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pcsm_pkg::cmd_t pop_cmd
);
  import pcsm_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/pcsm_back.sv =====
// back end: scan walker and two-slot result buffer
// depends on pcsm_pkg, pcsm_report_if and the assertion macro header
`timescale 1ns / 1ps
`include "pci_config_scan_matcher_defines.svh"

module pcsm_back #(
  parameter int BUS_COUNT  = pcsm_pkg::BUS_COUNT_DEF,
  parameter int SLOT_COUNT = pcsm_pkg::SLOT_COUNT_DEF,
  parameter int FUNC_COUNT = pcsm_pkg::FUNC_COUNT_DEF,
  parameter int BAR_COUNT  = pcsm_pkg::BAR_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pcsm_pkg::cfg_t  cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pcsm_pkg::cmd_t  pop_cmd,
  pcsm_report_if.source   report
);
  import pcsm_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_PROBE = 7'b0000010,
    PH_HDR   = 7'b0000100,
    PH_FID   = 7'b0001000,
    PH_FCLS  = 7'b0010000,
    PH_CLS   = 7'b0100000,
    PH_BAR   = 7'b1000000
  } phase_t;

  localparam logic [8:0] BUS_LIM  = 9'(BUS_COUNT);
  localparam logic [5:0] SLOT_LIM = 6'(SLOT_COUNT);
  localparam logic [3:0] FUNC_LIM = 4'(FUNC_COUNT);
  localparam logic [3:0] BAR_LIM  = 4'(BAR_COUNT);

  phase_t      phase, phase_next;
  logic [7:0]  scan_bus, scan_bus_next;
  logic [4:0]  scan_slot, scan_slot_next;
  logic [2:0]  scan_func, scan_func_next;
  logic [3:0]  func_limit, func_limit_next;
  logic [15:0] hits_seen, hits_seen_next;
  logic [31:0] held_id, held_id_next;
  logic [23:0] held_class, held_class_next;
  logic [2:0]  bar_counter, bar_counter_next;

  result_t     slot0, slot1;
  logic [1:0]  count;
  result_t     first, second;
  logic [1:0]  produced;

  logic        take;
  logic        report_fire;
  logic [1:0]  mode;
  logic        do_hit, do_func, do_slot;
  logic        req, bar_rep, found, not_found;
  logic [2:0]  req_fn;
  logic [7:0]  req_off;
  result_t     req_res, bar_res, found_res, nf_res;

  assign report_fire = report.valid && report.ready;
  assign pop_ready   = (count == 2'd0) || ((count == 2'd1) && report_fire);
  assign take        = pop_valid && pop_ready;
  assign mode        = (cfg.mode == 2'd3) ? MODE_ANY : cfg.mode;

  always_comb begin
    phase_next       = phase;
    scan_bus_next    = scan_bus;
    scan_slot_next   = scan_slot;
    scan_func_next   = scan_func;
    func_limit_next  = func_limit;
    hits_seen_next   = hits_seen;
    held_id_next     = held_id;
    held_class_next  = held_class;
    bar_counter_next = bar_counter;
    do_hit    = 1'b0;
    do_func   = 1'b0;
    do_slot   = 1'b0;
    req       = 1'b0;
    bar_rep   = 1'b0;
    found     = 1'b0;
    not_found = 1'b0;
    req_fn    = '0;
    req_off   = OFF_ID;

    if (take) begin
      if (pop_cmd.start) begin
        scan_bus_next    = '0;
        scan_slot_next   = '0;
        scan_func_next   = '0;
        func_limit_next  = 4'd1;
        hits_seen_next   = '0;
        bar_counter_next = '0;
        phase_next       = PH_PROBE;
        req              = 1'b1;
      end else begin
        case (phase)
          PH_PROBE: begin
            if (pop_cmd.absent) begin
              do_slot = 1'b1;
            end else if (mode == MODE_ID) begin
              held_id_next    = pop_cmd.data;
              scan_func_next  = '0;
              func_limit_next = 4'd1;
              if (pop_cmd.id_match) begin
                do_hit = 1'b1;
              end else begin
                do_slot = 1'b1;
              end
            end else begin
              phase_next = PH_HDR;
              req        = 1'b1;
              req_off    = OFF_HDR;
            end
          end
          PH_HDR: begin
            func_limit_next = pop_cmd.multi ? FUNC_LIM : 4'd1;
            scan_func_next  = '0;
            phase_next      = PH_FID;
            req             = 1'b1;
          end
          PH_FID: begin
            if (pop_cmd.absent) begin
              do_func = 1'b1;
            end else begin
              held_id_next = pop_cmd.data;
              if (mode == MODE_CLASS) begin
                phase_next = PH_FCLS;
                req        = 1'b1;
                req_fn     = scan_func;
                req_off    = OFF_CLASS;
              end else begin
                do_hit = 1'b1;
              end
            end
          end
          PH_FCLS: begin
            held_class_next = pop_cmd.data[31:8];
            if (pop_cmd.class_match) begin
              do_hit = 1'b1;
            end else begin
              do_func = 1'b1;
            end
          end
          PH_CLS: begin
            held_class_next  = pop_cmd.data[31:8];
            bar_counter_next = '0;
            phase_next       = PH_BAR;
            req              = 1'b1;
            req_fn           = scan_func;
            req_off          = OFF_BAR;
          end
          PH_BAR: begin
            bar_rep = 1'b1;
            if (({1'b0, bar_counter} + 4'd1) < BAR_LIM) begin
              bar_counter_next = bar_counter + 3'd1;
              req              = 1'b1;
              req_fn           = scan_func;
              req_off          = OFF_BAR + {3'b000, bar_counter_next, 2'b00};
            end else begin
              found      = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end

      // chosen hit reads the class dword, otherwise count it and move on
      if (do_hit) begin
        if (hits_seen_next == cfg.index) begin
          phase_next = PH_CLS;
          req        = 1'b1;
          req_fn     = scan_func_next;
          req_off    = OFF_CLASS;
        end else begin
          hits_seen_next = hits_seen_next + 16'd1;
          do_func        = 1'b1;
        end
      end

      if (do_func) begin
        if (({1'b0, scan_func_next} + 4'd1) < func_limit_next) begin
          scan_func_next = scan_func_next + 3'd1;
          phase_next     = PH_FID;
          req            = 1'b1;
          req_fn         = scan_func_next;
          req_off        = OFF_ID;
        end else begin
          do_slot = 1'b1;
        end
      end

      if (do_slot) begin
        scan_func_next  = '0;
        func_limit_next = 4'd1;
        if (({1'b0, scan_slot_next} + 6'd1) < SLOT_LIM) begin
          scan_slot_next = scan_slot_next + 5'd1;
          phase_next     = PH_PROBE;
          req            = 1'b1;
          req_fn         = '0;
          req_off        = OFF_ID;
        end else if (({1'b0, scan_bus_next} + 9'd1) < BUS_LIM) begin
          scan_bus_next  = scan_bus_next + 8'd1;
          scan_slot_next = '0;
          phase_next     = PH_PROBE;
          req            = 1'b1;
          req_fn         = '0;
          req_off        = OFF_ID;
        end else begin
          not_found  = 1'b1;
          phase_next = PH_IDLE;
        end
      end
    end
  end

  // result records
  always_comb begin
    req_res             = '0;
    req_res.kind        = KIND_READ;
    req_res.cfg_address = {1'b1, 7'b0000000, scan_bus_next, scan_slot_next, req_fn,
                           req_off[7:2], 2'b00};

    bar_res           = '0;
    bar_res.kind      = KIND_BAR;
    bar_res.bar_index = bar_counter;
    bar_res.bar_value = pop_cmd.data;

    found_res                 = '0;
    found_res.kind            = KIND_FOUND;
    found_res.bus_number      = scan_bus_next;
    found_res.slot_number     = scan_slot_next;
    found_res.function_number = scan_func_next;
    found_res.id_word         = held_id_next;
    found_res.class_triple    = held_class_next;

    nf_res      = '0;
    nf_res.kind = KIND_NOT_FOUND;

    first    = '0;
    second   = '0;
    produced = 2'd0;
    if (bar_rep) begin
      first       = bar_res;
      second      = req ? req_res : found_res;
      second.last = 1'b1;
      produced    = 2'd2;
    end else if (req) begin
      first      = req_res;
      first.last = 1'b1;
      produced   = 2'd1;
    end else if (not_found) begin
      first      = nf_res;
      first.last = 1'b1;
      produced   = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      scan_bus    <= '0;
      scan_slot   <= '0;
      scan_func   <= '0;
      func_limit  <= 4'd1;
      hits_seen   <= '0;
      held_id     <= '0;
      held_class  <= '0;
      bar_counter <= '0;
      count       <= '0;
    end else begin
      phase       <= phase_next;
      scan_bus    <= scan_bus_next;
      scan_slot   <= scan_slot_next;
      scan_func   <= scan_func_next;
      func_limit  <= func_limit_next;
      hits_seen   <= hits_seen_next;
      held_id     <= held_id_next;
      held_class  <= held_class_next;
      bar_counter <= bar_counter_next;
      if (take) begin
        count <= produced;
      end else if (report_fire) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0 <= first;
      slot1 <= second;
    end else if (report_fire) begin
      slot0 <= slot1;
    end
  end

  assign report.valid           = (count != 2'd0);
  assign report.kind            = slot0.kind;
  assign report.cfg_address     = slot0.cfg_address;
  assign report.bar_index       = slot0.bar_index;
  assign report.bar_value       = slot0.bar_value;
  assign report.bus_number      = slot0.bus_number;
  assign report.slot_number     = slot0.slot_number;
  assign report.function_number = slot0.function_number;
  assign report.id_word         = slot0.id_word;
  assign report.class_triple    = slot0.class_triple;
  assign report.last            = slot0.last;

  `PCSM_ASSERT(a_count_range, clk, rst, count != 2'd3)
  `PCSM_ASSERT(a_bar_not_last, clk, rst, (report.valid && (slot0.kind == KIND_BAR)) |-> (!slot0.last && (count == 2'd2)))
  `PCSM_ASSERT(a_found_idle, clk, rst, ((count == 2'd2) && (slot1.kind == KIND_FOUND)) |-> (phase == PH_IDLE))
  `PCSM_ASSERT(a_hold_when_full, clk, rst, ((count == 2'd2) && !report.ready) |=> ((count == 2'd2) && $stable(slot0)))

endmodule

// ===== rtl/core/pci_config_scan_matcher.sv =====
// top level of the pci config scan matcher: config registers, front, queue, back
// depends on pcsm_pkg, pcsm_if, pcsm_front, pcsm_queue and pcsm_back
`timescale 1ns / 1ps
//
// channel   role    handshake      payload
// feed      sink    valid/ready    operation, read_data
// report    source  valid/ready    kind, cfg_address, bar fields, found record, last
// cfg       write   cfg_write      cfg_index, cfg_data
//
// an item enters the queue in the cycle it is offered while the queue has room
// the back takes one queued item per cycle when its result buffer frees up; a bar
//   dword makes two results and so holds the back until the second of them leaves on report
// a result is offered on report the cycle after the back takes its item; between feed
//   and report an item passes the queue memory and then the result buffer register
// the two-entry queue lets feed run two items ahead while report is stalled
// rst is synchronous: clears config registers, walker state, queue and buffer

module pci_config_scan_matcher #(
  parameter int BUS_COUNT  = pcsm_pkg::BUS_COUNT_DEF,
  parameter int SLOT_COUNT = pcsm_pkg::SLOT_COUNT_DEF,
  parameter int FUNC_COUNT = pcsm_pkg::FUNC_COUNT_DEF,
  parameter int BAR_COUNT  = pcsm_pkg::BAR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pcsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcsm_pkg::CFG_W-1:0]       cfg_data,
  pcsm_feed_if.sink                        feed,
  pcsm_report_if.source                    report
);
  import pcsm_pkg::*;

  cfg_t cfg;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // config registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:   cfg.mode      <= cfg_data[1:0];
        REG_VENDOR: cfg.vendor    <= cfg_data[15:0];
        REG_DEVICE: cfg.device    <= cfg_data[15:0];
        REG_CLASS:  cfg.class_val <= cfg_data[23:0];
        REG_INDEX:  cfg.index     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify the returned dword
  pcsm_front u_front (
    .feed       (feed),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short queue so front and back stall independently
  pcsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: scan walker and result buffer
  pcsm_back #(
    .BUS_COUNT  (BUS_COUNT),
    .SLOT_COUNT (SLOT_COUNT),
    .FUNC_COUNT (FUNC_COUNT),
    .BAR_COUNT  (BAR_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .report    (report)
  );

endmodule

// ===== tb/tb_pci_config_scan_matcher.sv =====
// self-checking testbench of the pci config scan matcher: directed table, then random scans
// depends on pcsm_pkg, pcsm_if and pci_config_scan_matcher
`timescale 1ns / 1ps

module tb_pci_config_scan_matcher;
  import pcsm_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1600;
  // mode code with no meaning of its own, walks like any present function
  localparam logic [1:0] MODE_ALIAS = 2'd3;

  typedef enum logic [2:0] {
    WALK_IDLE, WALK_PROBE, WALK_HDR, WALK_FUNC_ID, WALK_FUNC_CLASS, WALK_CLASS, WALK_BAR
  } walk_t;

  // one line of the directed table: a register write or an item, with an optional
  // read address typed in by hand
  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] sel;
    logic [CFG_W-1:0]     val;
    logic                 op;
    logic [31:0]          data;
    logic                 has_lit;
    logic [31:0]          lit_addr;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  pcsm_feed_if   feed();
  pcsm_report_if report();

  pci_config_scan_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feed      (feed),
    .report    (report)
  );

  always #4 clk = ~clk;

  // register copies as the block should hold them
  logic [1:0]  want_mode = MODE_ANY;
  logic [15:0] want_vendor = '0;
  logic [15:0] want_device = '0;
  logic [23:0] want_class = '0;
  logic [15:0] want_index = '0;

  // walk position and held fields of the predicted scan
  walk_t       walk_phase = WALK_IDLE;
  logic [7:0]  at_bus = '0;
  logic [4:0]  at_slot = '0;
  logic [2:0]  at_func = '0;
  logic [3:0]  func_span = 4'd1;
  logic [15:0] hit_count = '0;
  logic [31:0] kept_id = '0;
  logic [23:0] kept_class = '0;
  logic [2:0]  bar_num = '0;

  result_t step_out[$];       // results of the item being predicted
  result_t owed_reports[$];   // results predicted but not yet seen on report

  int  err_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  feed_calm = 1'b0;      // no gaps between feed items
  bit  quiet_report = 1'b0;   // report side never stalls

  // ---------------------------------------------------------------------------
  // predictor of the scan walk
  // ---------------------------------------------------------------------------

  // mechanism-1 address: enable bit, bus, slot, function, dword offset
  task automatic add_read(input logic [2:0] fn, input logic [7:0] off);
    result_t r;
    r = '0;
    r.kind = KIND_READ;
    r.cfg_address = {8'h80, at_bus, at_slot, fn, off[7:2], 2'b00};
    step_out.push_back(r);
  endtask

  // move to function 0 of the next slot, or give up past the last bus
  task automatic move_to_next_slot();
    result_t r;
    at_func = '0;
    func_span = 4'd1;
    if (int'(at_slot) + 1 < SLOT_COUNT_DEF) begin
      at_slot = at_slot + 5'd1;
    end else if (int'(at_bus) + 1 < BUS_COUNT_DEF) begin
      at_bus = at_bus + 8'd1;
      at_slot = '0;
    end else begin
      r = '0;
      r.kind = KIND_NOT_FOUND;
      step_out.push_back(r);
      walk_phase = WALK_IDLE;
      return;
    end
    walk_phase = WALK_PROBE;
    add_read('0, OFF_ID);
  endtask

  task automatic move_to_next_func();
    if (int'(at_func) + 1 < int'(func_span)) begin
      at_func = at_func + 3'd1;
      walk_phase = WALK_FUNC_ID;
      add_read(at_func, OFF_ID);
    end else begin
      move_to_next_slot();
    end
  endtask

  // a matching function: either the one asked for, or one more to count
  task automatic count_hit();
    if (hit_count == want_index) begin
      walk_phase = WALK_CLASS;
      add_read(at_func, OFF_CLASS);
    end else begin
      hit_count = hit_count + 16'd1;
      move_to_next_func();
    end
  endtask

  task automatic walk_step(input logic op, input logic [31:0] d);
    logic [1:0] eff_mode;
    result_t    r;
    // the unused mode code falls back to matching any function
    eff_mode = (want_mode == MODE_ID || want_mode == MODE_CLASS) ? want_mode : MODE_ANY;
    step_out.delete();
    if (op == OP_START) begin
      at_bus = '0;
      at_slot = '0;
      at_func = '0;
      func_span = 4'd1;
      hit_count = '0;
      bar_num = '0;
      walk_phase = WALK_PROBE;
      add_read('0, OFF_ID);
    end else begin
      case (walk_phase)
        WALK_PROBE: begin
          if (d[15:0] == VENDOR_NONE) begin
            move_to_next_slot();
          end else if (eff_mode == MODE_ID) begin
            // id mode looks at function 0 only, no header read
            kept_id = d;
            at_func = '0;
            func_span = 4'd1;
            if (d[15:0] == want_vendor && d[31:16] == want_device) count_hit();
            else move_to_next_slot();
          end else begin
            walk_phase = WALK_HDR;
            add_read('0, OFF_HDR);
          end
        end
        WALK_HDR: begin
          func_span = d[HDR_MULTI_BIT] ? 4'(FUNC_COUNT_DEF) : 4'd1;
          at_func = '0;
          walk_phase = WALK_FUNC_ID;
          add_read('0, OFF_ID);
        end
        WALK_FUNC_ID: begin
          if (d[15:0] == VENDOR_NONE) begin
            move_to_next_func();
          end else begin
            kept_id = d;
            if (eff_mode == MODE_CLASS) begin
              walk_phase = WALK_FUNC_CLASS;
              add_read(at_func, OFF_CLASS);
            end else begin
              count_hit();
            end
          end
        end
        WALK_FUNC_CLASS: begin
          kept_class = d[31:8];
          if (kept_class == want_class) count_hit();
          else move_to_next_func();
        end
        WALK_CLASS: begin
          kept_class = d[31:8];
          bar_num = '0;
          walk_phase = WALK_BAR;
          add_read(at_func, OFF_BAR);
        end
        WALK_BAR: begin
          r = '0;
          r.kind = KIND_BAR;
          r.bar_index = bar_num;
          r.bar_value = d;
          step_out.push_back(r);
          if (int'(bar_num) + 1 < BAR_COUNT_DEF) begin
            bar_num = bar_num + 3'd1;
            add_read(at_func, OFF_BAR + {3'b000, bar_num, 2'b00});
          end else begin
            r = '0;
            r.kind = KIND_FOUND;
            r.bus_number = at_bus;
            r.slot_number = at_slot;
            r.function_number = at_func;
            r.id_word = kept_id;
            r.class_triple = kept_class;
            step_out.push_back(r);
            walk_phase = WALK_IDLE;
          end
        end
        default: ;  // data with no scan running is dropped
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic log_failure(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) log_failure($sformatf("%s got %h want %h", name, got, want));
  endtask

  // report side: compare every accepted item, then stall for a drawn number of cycles
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && report.valid === 1'b1 && report.ready === 1'b1) begin
      got = {report.kind, report.cfg_address, report.bar_index, report.bar_value,
             report.bus_number, report.slot_number, report.function_number,
             report.id_word, report.class_triple, report.last};
      if (owed_reports.size() == 0) begin
        log_failure($sformatf("unexpected report item, kind %0d", got.kind));
      end else begin
        want = owed_reports.pop_front();
        cmp_field("kind", 32'(got.kind), 32'(want.kind));
        cmp_field("cfg_address", got.cfg_address, want.cfg_address);
        cmp_field("bar_index", 32'(got.bar_index), 32'(want.bar_index));
        cmp_field("bar_value", got.bar_value, want.bar_value);
        cmp_field("bus_number", 32'(got.bus_number), 32'(want.bus_number));
        cmp_field("slot_number", 32'(got.slot_number), 32'(want.slot_number));
        cmp_field("function_number", 32'(got.function_number), 32'(want.function_number));
        cmp_field("id_word", got.id_word, want.id_word);
        cmp_field("class_triple", 32'(got.class_triple), 32'(want.class_triple));
        cmp_field("last", 32'(got.last), 32'(want.last));
      end
      stall_left = quiet_report ? 0 : $urandom_range(0, 16);
    end
    if (rst) begin
      report.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      report.ready <= 1'b0;
    end else begin
      report.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one item after a drawn gap, predict its results once accepted;
  // a hand-typed read address replaces the prediction where given
  task automatic send_item(input logic op, input logic [31:0] data,
                           input logic use_lit, input logic [31:0] lit_addr);
    int      gap;
    result_t lit;
    gap = feed_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid <= 1'b1;
    feed.operation <= op;
    feed.read_data <= data;
    do @(posedge clk); while (feed.ready !== 1'b1);
    walk_step(op, data);
    if (use_lit) begin
      lit = '0;
      lit.kind = KIND_READ;
      lit.cfg_address = lit_addr;
      lit.last = 1'b1;
      step_out.delete();
      step_out.push_back(lit);
    end
    foreach (step_out[i]) owed_reports.push_back(step_out[i]);
  endtask

  // stop feeding, wait for every owed item, then let the block drain
  task automatic settle();
    feed.valid <= 1'b0;
    do @(posedge clk); while (owed_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      REG_MODE:   want_mode = val[1:0];
      REG_VENDOR: want_vendor = val[15:0];
      REG_DEVICE: want_device = val[15:0];
      REG_CLASS:  want_class = val[23:0];
      REG_INDEX:  want_index = val[15:0];
      default: ;
    endcase
  endtask

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                        input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '{1'b1, sel, val, OP_START, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic [31:0] data,
                                         input logic has_lit, input logic [31:0] lit_addr);
    plan_row_t row;
    row = '{1'b0, REG_MODE, '0, op, data, has_lit, lit_addr};
    return row;
  endfunction

  initial begin
    plan_row_t   plan[$];
    int          random_items;
    int          cap;
    int          count;
    logic        op;
    logic [31:0] data;
    logic [15:0] pick;

    feed.valid = 1'b0;
    feed.operation = OP_START;
    feed.read_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset registers: any function, first hit
    plan.push_back(item_row(OP_DATA, 32'hFFFF_FFFF, 1'b0, '0));         // no scan, dropped
    plan.push_back(item_row(OP_START, 32'h0000_0000, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(OP_DATA, 32'hFFFF_FFFF, 1'b1, 32'h8000_0800)); // empty slot 0
    plan.push_back(item_row(OP_DATA, 32'h1234_5678, 1'b1, 32'h8000_080C)); // header read
    plan.push_back(item_row(OP_DATA, 32'h0080_0000, 1'b1, 32'h8000_0800)); // multi-function
    plan.push_back(item_row(OP_DATA, 32'hFFFF_FFFF, 1'b1, 32'h8000_0900)); // function 0 absent
    plan.push_back(item_row(OP_DATA, 32'h0000_0000, 1'b1, 32'h8000_0908)); // hit on function 1
    plan.push_back(item_row(OP_DATA, 32'hFFFF_FFFF, 1'b0, '0));         // class dword
    plan.push_back(item_row(OP_DATA, 32'h0000_0000, 1'b0, '0));         // six bars, then found
    plan.push_back(item_row(OP_DATA, 32'hFFFF_FFFF, 1'b0, '0));
    plan.push_back(item_row(OP_DATA, 32'hAAAA_AAAA, 1'b0, '0));
    plan.push_back(item_row(OP_DATA, 32'h5555_5555, 1'b0, '0));
    plan.push_back(item_row(OP_DATA, 32'h8000_0001, 1'b0, '0));
    plan.push_back(item_row(OP_DATA, 32'h7FFF_FFFE, 1'b0, '0));
    plan.push_back(item_row(OP_DATA, 32'h0000_0000, 1'b0, '0));         // after found, dropped
    // undefined mode code, highest hit index
    plan.push_back(cfg_row(REG_MODE, CFG_W'(MODE_ALIAS)));
    plan.push_back(cfg_row(REG_INDEX, 24'h00_FFFF));
    plan.push_back(cfg_row(REG_CLASS, 24'hFF_FFFF));
    plan.push_back(item_row(OP_START, 32'h0000_0000, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(OP_DATA, 32'h0001_0001, 1'b1, 32'h8000_000C));
    plan.push_back(item_row(OP_START, 32'h0000_0000, 1'b1, 32'h8000_0000)); // abort mid-scan
    plan.push_back(item_row(OP_DATA, 32'hFFFF_0000, 1'b1, 32'h8000_000C));
    plan.push_back(item_row(OP_DATA, 32'h0000_0000, 1'b0, '0));         // single function
    plan.push_back(item_row(OP_DATA, 32'h0001_0001, 1'b0, '0));         // hit, counted only
    // vendor and device id mode
    plan.push_back(cfg_row(REG_MODE, CFG_W'(MODE_ID)));
    plan.push_back(cfg_row(REG_VENDOR, 24'h00_1234));
    plan.push_back(cfg_row(REG_DEVICE, 24'h00_ABCD));
    plan.push_back(cfg_row(REG_INDEX, 24'h00_0000));
    plan.push_back(item_row(OP_START, 32'h0000_0000, 1'b1, 32'h8000_0000));
    plan.push_back(item_row(OP_DATA, 32'hABCD_1234, 1'b1, 32'h8000_0008)); // id hit, class read
    plan.push_back(item_row(OP_DATA, 32'h0C03_3000, 1'b0, '0));
    plan.push_back(item_row(OP_START, 32'h0000_0000, 1'b1, 32'h8000_0000));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].sel, plan[i].val);
      end else begin
        send_item(plan[i].op, plan[i].data, plan[i].has_lit, plan[i].lit_addr);
      end
    end

    // random scans: mostly well-formed answers shaped by where the walk stands,
    // with stray starts and garbage mixed in
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        if ($urandom_range(0, 1)) write_reg(REG_MODE, CFG_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1)) begin
          pick = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                             : 16'($urandom);
          write_reg(REG_VENDOR, CFG_W'(pick));
        end
        if ($urandom_range(0, 1)) begin
          pick = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                             : 16'($urandom);
          write_reg(REG_DEVICE, CFG_W'(pick));
        end
        if ($urandom_range(0, 1)) begin
          write_reg(REG_CLASS, ($urandom_range(0, 3) == 0)
                                 ? ($urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000)
                                 : CFG_W'($urandom));
        end
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 7))
            0:       pick = 16'hFFFF;
            1:       pick = 16'($urandom);
            default: pick = 16'($urandom_range(0, 3));
          endcase
          write_reg(REG_INDEX, CFG_W'(pick));
        end
      end
      feed_calm = ($urandom_range(0, 3) == 0);
      quiet_report = ($urandom_range(0, 3) == 0);

      send_item(OP_START, 32'($urandom), 1'b0, '0);
      random_items++;
      cap = $urandom_range(4, 60);
      count = 0;
      while (walk_phase != WALK_IDLE && count < cap) begin
        op = OP_DATA;
        data = $urandom;
        if ($urandom_range(0, 29) == 0) begin
          // stray item: a restart or data out of step
          op = $urandom_range(0, 1) ? OP_DATA : OP_START;
        end else begin
          case (walk_phase)
            WALK_PROBE: begin
              if ($urandom_range(0, 99) < 35) begin
                data = {16'($urandom), VENDOR_NONE};
              end else if (want_mode == MODE_ID && $urandom_range(0, 1)) begin
                data = {want_device, want_vendor};
              end else if (data[15:0] == VENDOR_NONE) begin
                data[0] = 1'b0;
              end
            end
            WALK_FUNC_ID: begin
              if ($urandom_range(0, 99) < 30) data[15:0] = VENDOR_NONE;
              else if (data[15:0] == VENDOR_NONE) data[0] = 1'b0;
            end
            WALK_FUNC_CLASS: begin
              if ($urandom_range(0, 1)) data = {want_class, 8'($urandom)};
            end
            default: begin
              // header, class and bar dwords, extremes now and then
              if ($urandom_range(0, 7) == 0) data = $urandom_range(0, 1) ? '1 : '0;
            end
          endcase
        end
        send_item(op, data, 1'b0, '0);
        count++;
        random_items++;
      end
      // data with no scan running should be dropped
      if (walk_phase == WALK_IDLE && $urandom_range(0, 7) == 0) begin
        send_item(OP_DATA, 32'($urandom), 1'b0, '0);
      end
    end

    settle();
    if (owed_reports.size() != 0) begin
      log_failure($sformatf("%0d report items never arrived", owed_reports.size()));
    end
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
